@@ hdl/pmrlc_pkg.sv @@
// Shared types and constants for the page map run-length clusterer.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package pmrlc_pkg;

  // Map limits and field widths
  localparam int unsigned MAX_PAGES  = 65536;
  localparam int unsigned USAGE_W    = 8;
  localparam int unsigned NUMBER_W   = 16;
  localparam int unsigned START_W    = 16;
  localparam int unsigned COUNT_W    = 17;
  localparam int unsigned SEEN_W     = $clog2(MAX_PAGES + 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMPORARY_CODE = 1'b0,
    CFG_FREE_CODE      = 1'b1
  } cfg_reg_e;

  localparam logic [USAGE_W-1:0] TEMP_CODE_RESET = 8'hFF;
  localparam logic [USAGE_W-1:0] FREE_CODE_RESET = 8'h00;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [USAGE_W-1:0] page_usage;
    logic               last_page;
  } page_in_t;

  typedef struct packed {
    logic [NUMBER_W-1:0] cluster_number;
    logic [START_W-1:0]  start_page;
    logic [COUNT_W-1:0]  page_count;
    logic [USAGE_W-1:0]  cluster_usage;
    logic                final_cluster;
    logic                overflow;
  } cluster_out_t;

  // Classified page passed from front to back
  typedef struct packed {
    logic [USAGE_W-1:0] usage;
    logic               last_page;
  } page_entry_t;

  // Queue handshake toward the back part
  typedef struct packed {
    logic        valid;
    page_entry_t entry;
  } q_head_t;

endpackage

@@ hdl/pmrlc_front.sv @@
// Front part: configuration registers and temporary-code remapping.
// Depends on pmrlc_pkg.
`timescale 1ns / 1ps

module pmrlc_front import pmrlc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  page_in_t              page_i,
  output page_entry_t           entry_o
);

  logic [USAGE_W-1:0] temp_code_q, temp_code_d;
  logic [USAGE_W-1:0] free_code_q, free_code_d;

  // Decode register writes
  always_comb begin
    temp_code_d = temp_code_q;
    free_code_d = free_code_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_TEMPORARY_CODE: temp_code_d = cfg_wdata_i[USAGE_W-1:0];
        CFG_FREE_CODE:      free_code_d = cfg_wdata_i[USAGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_code_q <= TEMP_CODE_RESET;
      free_code_q <= FREE_CODE_RESET;
    end else begin
      temp_code_q <= temp_code_d;
      free_code_q <= free_code_d;
    end
  end

  // Remap temporary pages to free
  always_comb begin
    entry_o.last_page = page_i.last_page;
    entry_o.usage     = (page_i.page_usage == temp_code_q) ? free_code_q : page_i.page_usage;
  end

endmodule

@@ hdl/pmrlc_queue.sv @@
// Short register queue between the front and back parts.
// Depends on pmrlc_pkg.
`timescale 1ns / 1ps

module pmrlc_queue import pmrlc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  page_entry_t push_data_i,
  output logic        full_o,
  input  logic        pop_i,
  output q_head_t     head_o
);

  page_entry_t        mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == Q_CNT_W'(Q_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && (count_q != '0);

  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ hdl/pmrlc_back.sv @@
// Back part: run tracking, cluster emission and output staging.
// Depends on pmrlc_pkg.
`timescale 1ns / 1ps

module pmrlc_back import pmrlc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  q_head_t      head_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output cluster_out_t out_data_o
);

  // Run state
  logic [USAGE_W-1:0]  open_usage_q, open_usage_d;
  logic [START_W-1:0]  open_start_q, open_start_d;
  logic [COUNT_W-1:0]  open_count_q, open_count_d;
  logic [NUMBER_W-1:0] done_q, done_d;
  logic [SEEN_W-1:0]   seen_q, seen_d;
  logic                open_q, open_d;
  logic                ovf_q, ovf_d;

  // Output register and second-result holding stage
  logic                out_valid_q, pend_valid_q;
  cluster_out_t        out_q, pend_q;

  logic                out_free;
  logic                page_over;
  logic                emit_first, emit_final;
  cluster_out_t        first_res, final_res;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = head_i.valid && !pend_valid_q && out_free;

  // Update run state for the head page
  always_comb begin
    open_usage_d = open_usage_q;
    open_start_d = open_start_q;
    open_count_d = open_count_q;
    done_d       = done_q;
    seen_d       = seen_q;
    open_d       = open_q;
    ovf_d        = ovf_q;
    emit_first   = 1'b0;
    emit_final   = 1'b0;
    page_over    = (seen_q >= SEEN_W'(MAX_PAGES));

    first_res.cluster_number = done_q;
    first_res.start_page     = open_start_q;
    first_res.page_count     = open_count_q;
    first_res.cluster_usage  = open_usage_q;
    first_res.final_cluster  = 1'b0;
    first_res.overflow       = ovf_q;

    if (page_over) begin
      ovf_d = 1'b1;
    end else begin
      if (!open_q || head_i.entry.usage != open_usage_q) begin
        emit_first   = open_q;
        open_d       = 1'b1;
        open_usage_d = head_i.entry.usage;
        open_start_d = seen_q[START_W-1:0];
        open_count_d = COUNT_W'(1);
      end else begin
        open_count_d = open_count_q + 1'b1;
      end
      seen_d = seen_q + 1'b1;
    end
    if (emit_first) done_d = done_q + 1'b1;

    final_res.cluster_number = done_d;
    final_res.start_page     = open_start_d;
    final_res.page_count     = open_count_d;
    final_res.cluster_usage  = open_usage_d;
    final_res.final_cluster  = 1'b1;
    final_res.overflow       = ovf_d;

    // Flush and restart the map on the last page
    if (head_i.entry.last_page) begin
      emit_final   = open_d;
      open_usage_d = '0;
      open_start_d = '0;
      open_count_d = '0;
      done_d       = '0;
      seen_d       = '0;
      open_d       = 1'b0;
      ovf_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_usage_q <= '0;
      open_start_q <= '0;
      open_count_q <= '0;
      done_q       <= '0;
      seen_q       <= '0;
      open_q       <= 1'b0;
      ovf_q        <= 1'b0;
    end else if (pop_o) begin
      open_usage_q <= open_usage_d;
      open_start_q <= open_start_d;
      open_count_q <= open_count_d;
      done_q       <= done_d;
      seen_q       <= seen_d;
      open_q       <= open_d;
      ovf_q        <= ovf_d;
    end
  end

  // Stage results: the held second result goes out before any new page
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (pend_valid_q && out_free) begin
      out_valid_q  <= 1'b1;
      pend_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q  <= emit_first || emit_final;
      pend_valid_q <= emit_first && emit_final;
    end else if (out_free) begin
      out_valid_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_valid_q && out_free) begin
      out_q <= pend_q;
    end else if (pop_o) begin
      out_q  <= emit_first ? first_res : final_res;
      pend_q <= final_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/page_map_run_length_clusterer_unit.sv @@
// Page map run-length clusterer, top level.
// Usage: one page usage code per input transfer, in page order, last_page on
// the final page of the map. Temporary codes are remapped to the free code,
// and runs of equal codes are reported as clusters on the output channel.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low. Registers are written through cfg_we_i/cfg_index_i/
// cfg_wdata_i (index 0 temporary code, 1 free code); the user must write
// them only while the block is idle, which the block does not enforce.
// A closing page goes through the queue and back part to the output register.
// Throughput: one page per cycle unless the output stalls; a page that
// closes one cluster and flushes the next emits two clusters and holds
// the back part until the second moves from its holding stage into the
// output register. A four-entry queue lets the input keep flowing while
// the output is stalled, until it is full; then the input is stalled.
// Results wait unchanged in the output register while out_stall_i is high.
// Reset: registers return to 255 (temporary) and 0 (free), the queue is
// emptied and no cluster is open; the first page starts a new map at page 0.
// Pages beyond 65536 in one map are dropped and set the overflow flag.
// Depends on pmrlc_pkg, pmrlc_front, pmrlc_queue and pmrlc_back.
`timescale 1ns / 1ps

module page_map_run_length_clusterer_unit import pmrlc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  page_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output cluster_out_t          out_data_o
);

  page_entry_t entry;
  q_head_t     head;
  logic        q_full;
  logic        pop;

  assign in_stall_o = q_full;

  pmrlc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .page_i      (in_data_i),
    .entry_o     (entry)
  );

  pmrlc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (entry),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_o      (head)
  );

  pmrlc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ tb/sv/tb_page_map_run_length_clusterer_unit.sv @@
// Self-checking testbench for page_map_run_length_clusterer_unit: directed pages
// and random maps under several codes.
// Depends on pmrlc_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_page_map_run_length_clusterer_unit;
  import pmrlc_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_TEMPORARY_CODE;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  page_in_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  cluster_out_t          out_data_o;

  page_map_run_length_clusterer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // Pages waiting to be driven and clusters waiting to come out
  page_in_t     pending_pages[$];
  cluster_out_t expected_clusters[$];
  int           mismatch_count = 0;

  // Shadow of the code registers and of the open map
  logic [USAGE_W-1:0]  temp_code_q = TEMP_CODE_RESET;
  logic [USAGE_W-1:0]  free_code_q = FREE_CODE_RESET;
  logic [USAGE_W-1:0]  run_usage = '0;
  logic [SEEN_W-1:0]   run_start = '0;
  logic [SEEN_W-1:0]   run_len = '0;
  logic [SEEN_W-1:0]   map_pages = '0;
  logic [NUMBER_W-1:0] map_clusters = '0;
  bit                  run_active = 1'b0;
  bit                  map_overflow = 1'b0;

  task automatic clear_map_state();
    run_usage    = '0;
    run_start    = '0;
    run_len      = '0;
    map_pages    = '0;
    map_clusters = '0;
    run_active   = 1'b0;
    map_overflow = 1'b0;
  endtask

  // Close the open run into an expected cluster
  task automatic push_cluster(input bit is_final);
    cluster_out_t c;
    c.cluster_number = map_clusters;
    c.start_page     = run_start[START_W-1:0];
    c.page_count     = run_len[COUNT_W-1:0];
    c.cluster_usage  = run_usage;
    c.final_cluster  = is_final;
    c.overflow       = map_overflow;
    expected_clusters.push_back(c);
    map_clusters = map_clusters + 1'b1;
  endtask

  // Advance the map by one accepted page
  task automatic cluster_page(input page_in_t pg);
    logic [USAGE_W-1:0] code;
    code = pg.page_usage;
    if (code == temp_code_q) code = free_code_q;
    if (map_pages >= MAX_PAGES) begin
      map_overflow = 1'b1;
    end else begin
      if (!run_active) begin
        run_active = 1'b1;
        run_usage  = code;
        run_start  = map_pages;
        run_len    = SEEN_W'(1);
      end else if (code == run_usage) begin
        run_len = run_len + 1'b1;
      end else begin
        push_cluster(1'b0);
        run_usage = code;
        run_start = map_pages;
        run_len   = SEEN_W'(1);
      end
      map_pages = map_pages + 1'b1;
    end
    if (pg.last_page) begin
      if (run_active) push_cluster(1'b1);
      clear_map_state();
    end
  endtask

  // Driver: bursts of transfers with random gaps, payload held while stalled
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) cluster_page(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_pages.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_pages.pop_front();
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall level redrawn at regular intervals; long hold-offs now and then
  int unsigned rx_cycles = 0;
  int          hold_left = 0;
  int          stall_level = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      rx_cycles++;
      if (rx_cycles % 1500 == 700) hold_left = 400;
      if (rx_cycles % 64 == 0) stall_level = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_level == 0) begin
        out_stall_i <= 1'b0;
      end else if (stall_level == 1) begin
        out_stall_i <= ($urandom_range(0, 7) == 0);
      end else begin
        out_stall_i <= ($urandom_range(0, 1) == 0);
      end
    end
  end

  task automatic check_field(input string field, input logic [COUNT_W-1:0] want_v,
                             input logic [COUNT_W-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0d got %0d", $time, field, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // Monitor: compare each cluster transfer with the oldest expectation
  cluster_out_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_clusters.size() == 0) begin
        $display("%0t: unexpected cluster expected none got %h", $time, out_data_o);
        mismatch_count++;
      end else begin
        want = expected_clusters.pop_front();
        check_field("cluster_number", COUNT_W'(want.cluster_number),
                    COUNT_W'(out_data_o.cluster_number));
        check_field("start_page", COUNT_W'(want.start_page),
                    COUNT_W'(out_data_o.start_page));
        check_field("page_count", want.page_count, out_data_o.page_count);
        check_field("cluster_usage", COUNT_W'(want.cluster_usage),
                    COUNT_W'(out_data_o.cluster_usage));
        check_field("final_cluster", COUNT_W'(want.final_cluster),
                    COUNT_W'(out_data_o.final_cluster));
        check_field("overflow", COUNT_W'(want.overflow), COUNT_W'(out_data_o.overflow));
      end
    end
  end

  task automatic add_page(input logic [USAGE_W-1:0] usage, input bit last);
    page_in_t pg;
    pg.page_usage = usage;
    pg.last_page  = last;
    pending_pages.push_back(pg);
  endtask

  task automatic write_register(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    if (idx == CFG_TEMPORARY_CODE) temp_code_q = value;
    else free_code_q = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drain everything, then cover the input queue plus the pipeline
  task automatic wait_idle();
    while (pending_pages.size() != 0 || in_valid_i || expected_clusters.size() != 0)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // Random maps built from runs, with codes biased toward the remapped ones
  task automatic queue_random_maps(input int budget);
    int                 queued;
    int                 len;
    int                 pick;
    logic [USAGE_W-1:0] cur;
    queued = 0;
    cur = USAGE_W'($urandom_range(0, 255));
    while (queued < budget) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) len = 1;
      else if (pick == 15) len = $urandom_range(100, 300);
      else len = $urandom_range(2, 30);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 7);
        if (pick == 4) cur = temp_code_q;
        else if (pick == 5) cur = free_code_q;
        else if (pick == 6) cur = USAGE_W'($urandom_range(0, 3));
        else if (pick == 7) cur = USAGE_W'($urandom_range(0, 255));
        add_page(cur, i == len - 1);
      end
      queued += len;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset codes: merge through the remap, code change with last page, single page
    add_page(8'h00, 1'b0);
    add_page(8'h00, 1'b0);
    add_page(8'hFF, 1'b0);
    add_page(8'h01, 1'b0);
    add_page(8'h01, 1'b1);
    add_page(8'h80, 1'b1);
    add_page(8'hFE, 1'b0);
    add_page(8'h7F, 1'b1);
    add_page(8'h55, 1'b0);
    add_page(8'hAA, 1'b0);
    add_page(8'h55, 1'b0);
    add_page(8'hFF, 1'b1);
    wait_idle();

    // Swapped extremes: zero pages become 0xFF
    write_register(CFG_TEMPORARY_CODE, 8'h00);
    write_register(CFG_FREE_CODE, 8'hFF);
    add_page(8'h00, 1'b0);
    add_page(8'hFF, 1'b0);
    add_page(8'h00, 1'b0);
    add_page(8'h01, 1'b0);
    add_page(8'h00, 1'b1);
    wait_idle();

    // Random maps under several code settings
    for (int seg = 0; seg < 4; seg++) begin
      if (seg == 0) begin
        write_register(CFG_TEMPORARY_CODE, CFG_DATA_W'($urandom_range(0, 255)));
        write_register(CFG_FREE_CODE, CFG_DATA_W'($urandom_range(0, 255)));
      end else if (seg == 1) begin
        write_register(CFG_TEMPORARY_CODE, 8'h00);
        write_register(CFG_FREE_CODE, 8'h00);
      end else if (seg == 2) begin
        write_register(CFG_TEMPORARY_CODE, 8'hFF);
        write_register(CFG_FREE_CODE, 8'hFF);
      end else begin
        write_register(CFG_TEMPORARY_CODE, CFG_DATA_W'($urandom_range(0, 3)));
        write_register(CFG_FREE_CODE, CFG_DATA_W'($urandom_range(0, 3)));
      end
      queue_random_maps(450);
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit well beyond the slowest correct run
  initial begin
    #1_600_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
